// ----- hdl/irf_pkg.sv -----
// Shared constants, codes and command types for the image region rotate/flip block.
`default_nettype none
package irf_pkg;

    // Store geometry: SIDE x SIDE pixels, address is {row, column}.
    localparam int SIDE       = 64;
    localparam int SIDE_BITS  = 6;
    localparam int ADDR_BITS  = 2 * SIDE_BITS;
    localparam int DEPTH      = SIDE * SIDE;
    localparam int PIX_BITS   = 8;
    localparam int OUT_BITS   = 8;
    localparam int LEN_BITS   = 7;
    localparam int SUM_BITS   = 8;

    // Operation codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_ROTATE = 2'd2,
        OP_FLIP   = 2'd3
    } op_t;

    // Mirror direction.
    localparam logic FLIP_LR = 1'b0;
    localparam logic FLIP_UD = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic                  use_pixel;
        logic                  grp4;
        logic [1:0]            idx;
        logic [ADDR_BITS-1:0]  addr;
        logic [PIX_BITS-1:0]   pixel;
        logic                  res_load;
        logic                  res_pixel;
        logic                  res_status;
    } irf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;
    } irf_stat_t;

endpackage
`default_nettype wire

// ----- hdl/irf_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module irf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/irf_datapath.sv -----
// Datapath: pixel store, swap group registers and the result register.
`default_nettype none
module irf_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire irf_pkg::irf_cmd_t  cmd,
    output irf_pkg::irf_stat_t      stat,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,   // pixel_out[7:0]
    output logic                    m_tuser    // status
);

    logic [irf_pkg::PIX_BITS-1:0] rdata;
    logic [irf_pkg::PIX_BITS-1:0] wdata;
    logic [irf_pkg::PIX_BITS-1:0] grp_reg [4];
    logic                         rd_pend_reg;
    logic [1:0]                   rd_idx_reg;
    logic [1:0]                   src_idx;
    logic                         m_tvalid_reg;
    logic [7:0]                   m_tdata_reg;
    logic                         m_tuser_reg;

    irf_ram #(
        .WIDTH (irf_pkg::PIX_BITS),
        .DEPTH (irf_pkg::DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (cmd.addr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (cmd.addr),
        .rdata (rdata)
    );

    // Each cell of a group takes the value of the next one round the group.
    always_comb begin
        if (cmd.grp4) begin
            src_idx = cmd.idx + 2'd1;
        end else begin
            src_idx = {1'b0, ~cmd.idx[0]};
        end
        wdata = cmd.use_pixel ? cmd.pixel : grp_reg[src_idx];
    end

    // Capture read data in the cycle after the read is issued.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd_en;
        end
        rd_idx_reg <= cmd.idx;
        if (rd_pend_reg) begin
            grp_reg[rd_idx_reg] <= rdata;
        end
    end

    // Result register: a new beat loads only when the slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.res_load) begin
            m_tdata_reg <= cmd.res_pixel ? grp_reg[0][irf_pkg::OUT_BITS-1:0] : '0;
            m_tuser_reg <= cmd.res_status;
        end
    end

    assign stat.out_full = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;

endmodule
`default_nettype wire

// ----- hdl/irf_ctrl.sv -----
// Controller: item decode, range check, loop counters and address generation.
`default_nettype none
module irf_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [39:0]        s_tdata,
    input  wire logic [1:0]         s_tuser,
    output irf_pkg::irf_cmd_t       cmd,
    input  wire irf_pkg::irf_stat_t stat
);

    localparam int SB = irf_pkg::SIDE_BITS;
    localparam int LB = irf_pkg::LEN_BITS;
    localparam int UB = irf_pkg::SUM_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_WRITE1, ST_READ, ST_WAIT, ST_WRITE, ST_NEXT, ST_RESULT
    } state_t;

    state_t                       state_reg;
    irf_pkg::op_t                 op_reg;
    logic [SB-1:0]                row_reg;
    logic [SB-1:0]                col_reg;
    logic [LB-1:0]                h_reg;
    logic [LB-1:0]                w_reg;
    logic [1:0]                   turns_reg;
    logic                         dir_reg;
    logic [irf_pkg::PIX_BITS-1:0] pix_reg;
    logic                         err_reg;
    logic [1:0]                   turn_reg;
    logic [LB-1:0]                outer_reg;
    logic [LB-1:0]                inner_reg;
    logic [1:0]                   cnt_reg;

    logic [UB-1:0] r8, c8, h8, w8, o8, i8;
    logic [UB-1:0] top8, left8, bot8, right8;
    logic [UB-1:0] rows8 [4];
    logic [UB-1:0] cols8 [4];
    logic [LB-1:0] inner_lim;
    logic [LB-1:0] outer_lim;
    logic [1:0]    grp_last;
    logic          range_err;
    logic          empty;

    // Extended operands for coordinate arithmetic.
    always_comb begin
        r8 = UB'(row_reg);
        c8 = UB'(col_reg);
        h8 = UB'(h_reg);
        w8 = UB'(w_reg);
        o8 = UB'(outer_reg);
        i8 = UB'(inner_reg);
    end

    // Corner coordinates of the current ring for rotation.
    always_comb begin
        top8   = r8 + o8;
        left8  = c8 + o8;
        bot8   = r8 + h8 - 8'd1 - o8;
        right8 = c8 + h8 - 8'd1 - o8;
    end

    // Cells of the current group and the loop limits for each operation.
    always_comb begin
        rows8[0] = r8;
        cols8[0] = c8;
        rows8[1] = r8;
        cols8[1] = c8;
        rows8[2] = r8;
        cols8[2] = c8;
        rows8[3] = r8;
        cols8[3] = c8;
        inner_lim = '0;
        outer_lim = '0;
        grp_last  = 2'd0;
        case (op_reg)
            irf_pkg::OP_ROTATE: begin
                rows8[0]  = top8;
                cols8[0]  = left8 + i8;
                rows8[1]  = bot8 - i8;
                cols8[1]  = left8;
                rows8[2]  = bot8;
                cols8[2]  = right8 - i8;
                rows8[3]  = top8 + i8;
                cols8[3]  = right8;
                inner_lim = h_reg - LB'({outer_reg, 1'b0}) - 7'd1;
                outer_lim = h_reg >> 1;
                grp_last  = 2'd3;
            end
            irf_pkg::OP_FLIP: begin
                grp_last = 2'd1;
                if (dir_reg == irf_pkg::FLIP_UD) begin
                    rows8[0]  = r8 + i8;
                    cols8[0]  = c8 + o8;
                    rows8[1]  = r8 + h8 - 8'd1 - i8;
                    cols8[1]  = c8 + o8;
                    inner_lim = h_reg >> 1;
                    outer_lim = w_reg;
                end else begin
                    rows8[0]  = r8 + o8;
                    cols8[0]  = c8 + i8;
                    rows8[1]  = r8 + o8;
                    cols8[1]  = c8 + w8 - 8'd1 - i8;
                    inner_lim = w_reg >> 1;
                    outer_lim = h_reg;
                end
            end
            default: begin
                grp_last = 2'd0;
            end
        endcase
    end

    // Range check and empty-region detection for the latched item.
    always_comb begin
        case (op_reg)
            irf_pkg::OP_ROTATE: begin
                range_err = (r8 + h8 > UB'(irf_pkg::SIDE)) || (c8 + h8 > UB'(irf_pkg::SIDE));
            end
            irf_pkg::OP_FLIP: begin
                range_err = (r8 + h8 > UB'(irf_pkg::SIDE)) || (c8 + w8 > UB'(irf_pkg::SIDE));
            end
            default: begin
                range_err = (r8 >= UB'(irf_pkg::SIDE)) || (c8 >= UB'(irf_pkg::SIDE));
            end
        endcase
        empty = (inner_lim == '0) || (outer_lim == '0) ||
                ((op_reg == irf_pkg::OP_ROTATE) && (turns_reg == 2'd0));
    end

    // Main sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
            turn_reg  <= 2'd0;
            outer_reg <= '0;
            inner_reg <= '0;
            err_reg   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= irf_pkg::op_t'(s_tuser);
                        row_reg   <= s_tdata[5:0];
                        col_reg   <= s_tdata[11:6];
                        h_reg     <= s_tdata[18:12];
                        w_reg     <= s_tdata[25:19];
                        turns_reg <= s_tdata[27:26];
                        dir_reg   <= s_tdata[28];
                        pix_reg   <= s_tdata[36:29];
                        cnt_reg   <= 2'd0;
                        turn_reg  <= 2'd0;
                        outer_reg <= '0;
                        inner_reg <= '0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    err_reg <= range_err;
                    if (range_err) begin
                        state_reg <= ST_RESULT;
                    end else if (op_reg == irf_pkg::OP_WRITE) begin
                        state_reg <= ST_WRITE1;
                    end else if (op_reg == irf_pkg::OP_READ) begin
                        state_reg <= ST_READ;
                    end else if (empty) begin
                        state_reg <= ST_RESULT;
                    end else begin
                        state_reg <= ST_READ;
                    end
                end
                ST_WRITE1: begin
                    state_reg <= ST_RESULT;
                end
                ST_READ: begin
                    if (cnt_reg == grp_last) begin
                        cnt_reg   <= 2'd0;
                        state_reg <= ST_WAIT;
                    end else begin
                        cnt_reg <= cnt_reg + 2'd1;
                    end
                end
                ST_WAIT: begin
                    state_reg <= (op_reg == irf_pkg::OP_READ) ? ST_RESULT : ST_WRITE;
                end
                ST_WRITE: begin
                    if (cnt_reg == grp_last) begin
                        cnt_reg   <= 2'd0;
                        state_reg <= ST_NEXT;
                    end else begin
                        cnt_reg <= cnt_reg + 2'd1;
                    end
                end
                ST_NEXT: begin
                    if (UB'(inner_reg) + 8'd1 < UB'(inner_lim)) begin
                        inner_reg <= inner_reg + 7'd1;
                        state_reg <= ST_READ;
                    end else if (UB'(outer_reg) + 8'd1 < UB'(outer_lim)) begin
                        outer_reg <= outer_reg + 7'd1;
                        inner_reg <= '0;
                        state_reg <= ST_READ;
                    end else if ((op_reg == irf_pkg::OP_ROTATE) &&
                                 (turn_reg + 2'd1 != turns_reg)) begin
                        turn_reg  <= turn_reg + 2'd1;
                        outer_reg <= '0;
                        inner_reg <= '0;
                        state_reg <= ST_READ;
                    end else begin
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!stat.out_full) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Command decode for the datapath.
    always_comb begin
        cmd            = '0;
        cmd.grp4       = (op_reg == irf_pkg::OP_ROTATE);
        cmd.idx        = cnt_reg;
        cmd.pixel      = pix_reg;
        cmd.res_pixel  = (op_reg == irf_pkg::OP_READ) && !err_reg;
        cmd.res_status = err_reg;
        if ((op_reg == irf_pkg::OP_WRITE) || (op_reg == irf_pkg::OP_READ)) begin
            cmd.addr = {row_reg, col_reg};
        end else begin
            cmd.addr = {rows8[cnt_reg][SB-1:0], cols8[cnt_reg][SB-1:0]};
        end
        case (state_reg)
            ST_WRITE1: begin
                cmd.wr_en     = 1'b1;
                cmd.use_pixel = 1'b1;
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
            end
            ST_WRITE: begin
                cmd.wr_en = 1'b1;
            end
            ST_RESULT: begin
                cmd.res_load = !stat.out_full;
            end
            default: begin
                cmd.rd_en = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/image_region_rotate_flip.sv -----
// A write passes the check, write and result states; a read the check, read, wait and result
// states; output stalls hold the result state. A rotate reads, then writes, each four-way swap
// group per quarter turn, a flip each swapped pair; 2 * 4096 store accesses per quarter turn at most.
// One item is in work at a time; the sequencer issues one store access at a time and sets the pace.
// The result register frees the input side while a finished beat waits downstream.
// Reset clears control state only; pixel store contents are undefined until written.
`default_nettype none
module image_region_rotate_flip (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // start_row[5:0], start_col[11:6], region_height[18:12],
                                       // region_width[25:19], quarter_turns[27:26],
                                       // flip_dir[28], pixel_in[36:29]
    input  wire logic [1:0]  s_tuser,  // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // pixel_out[7:0]
    output logic             m_tuser   // status[0]
);

    irf_pkg::irf_cmd_t  cmd;
    irf_pkg::irf_stat_t stat;

    irf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

    irf_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the image region rotate/flip block.
`default_nettype none
module tb_top;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int RANDOM_ITEMS = 29;

    // One expected result beat.
    typedef struct {
        logic [7:0] pixel;
        logic       status;
    } pixel_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;  // start_row, start_col, region_height, region_width,
                                // quarter_turns, flip_dir, pixel_in
    logic [1:0]  s_tuser = '0;  // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;       // pixel_out
    logic        m_tuser;       // status

    // Shadow copy of the pixel store and which entries hold written data.
    logic [7:0]      shadow_img [irf_pkg::SIDE][irf_pkg::SIDE];
    bit              written [irf_pkg::SIDE][irf_pkg::SIDE];
    pixel_result_t   pending_results [$];
    int              n_errors = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    longint          n_cycles = 0;

    image_region_rotate_flip i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL image_region_rotate_flip");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result beat with the oldest prediction; inputs settle well before negedge.
    always @(negedge aclk) begin
        pixel_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: pixel_out %0d status %0d", m_tdata, m_tuser);
                n_errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata !== exp_res.pixel) begin
                    $error("pixel_out: expected %0d, got %0d", exp_res.pixel, m_tdata);
                    n_errors++;
                end
                if (m_tuser !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, m_tuser);
                    n_errors++;
                end
            end
        end
    end

    // One clockwise quarter turn of the square at (r0, c0) with side n.
    function automatic void turn_quarter(int r0, int c0, int n);
        logic [7:0] old_px [irf_pkg::SIDE][irf_pkg::SIDE];
        bit         old_wr [irf_pkg::SIDE][irf_pkg::SIDE];
        old_px = shadow_img;
        old_wr = written;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                shadow_img[r0+i][c0+j] = old_px[r0+n-1-j][c0+i];
                written[r0+i][c0+j]    = old_wr[r0+n-1-j][c0+i];
            end
        end
    endfunction

    function automatic void swap_pixels(int ra, int ca, int rb, int cb);
        logic [7:0] tp;
        bit         tw;
        tp = shadow_img[ra][ca];
        shadow_img[ra][ca] = shadow_img[rb][cb];
        shadow_img[rb][cb] = tp;
        tw = written[ra][ca];
        written[ra][ca] = written[rb][cb];
        written[rb][cb] = tw;
    endfunction

    // Apply one item to the shadow store and return the result it gives.
    function automatic pixel_result_t predict_pixel_op(irf_pkg::op_t op, int row, int col,
                                                      int h, int w, int turns, logic dir,
                                                      logic [7:0] pix);
        pixel_result_t res;
        res.pixel  = '0;
        res.status = 1'b0;
        case (op)
            irf_pkg::OP_WRITE: begin
                shadow_img[row][col] = pix;
                written[row][col]    = 1'b1;
            end
            irf_pkg::OP_READ: res.pixel = shadow_img[row][col];
            irf_pkg::OP_ROTATE: begin
                if (row + h > irf_pkg::SIDE || col + h > irf_pkg::SIDE) res.status = 1'b1;
                else for (int t = 0; t < turns; t++) turn_quarter(row, col, h);
            end
            default: begin
                if (row + h > irf_pkg::SIDE || col + w > irf_pkg::SIDE) res.status = 1'b1;
                else if (dir == irf_pkg::FLIP_LR) begin
                    for (int i = 0; i < h; i++)
                        for (int j = 0; j < w / 2; j++)
                            swap_pixels(row + i, col + j, row + i, col + w - 1 - j);
                end else begin
                    for (int j = 0; j < w; j++)
                        for (int i = 0; i < h / 2; i++)
                            swap_pixels(row + i, col + j, row + h - 1 - i, col + j);
                end
            end
        endcase
        return res;
    endfunction

    // Send one item; valid stays high into the next item unless an idle gap is taken.
    task automatic send_pixel_op(irf_pkg::op_t op, int row, int col, int h = 0, int w = 0,
                                 int turns = 0, logic dir = irf_pkg::FLIP_LR,
                                 logic [7:0] pix = '0);
        pixel_result_t res;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        res = predict_pixel_op(op, row, col, h, w, turns, dir, pix);
        pending_results = {pending_results, res};
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, pix, dir, turns[1:0], w[6:0], h[6:0], col[5:0], row[5:0]};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    // Pixel writes and reads at the corners with extreme values.
    task automatic test_corner_pixels();
        send_pixel_op(irf_pkg::OP_WRITE, 0, 0, 0, 0, 0, irf_pkg::FLIP_LR, 8'd0);
        send_pixel_op(irf_pkg::OP_WRITE, 63, 63, 0, 0, 0, irf_pkg::FLIP_LR, 8'd255);
        send_pixel_op(irf_pkg::OP_WRITE, 0, 63, 0, 0, 0, irf_pkg::FLIP_LR, 8'hA5);
        send_pixel_op(irf_pkg::OP_WRITE, 63, 0, 0, 0, 0, irf_pkg::FLIP_LR, 8'h5A);
        send_pixel_op(irf_pkg::OP_READ, 0, 0);
        send_pixel_op(irf_pkg::OP_READ, 63, 63);
        send_pixel_op(irf_pkg::OP_READ, 0, 63);
        send_pixel_op(irf_pkg::OP_READ, 63, 0);
    endtask

    // Whole-store rotate and flips, empty and degenerate regions, out-of-range regions.
    task automatic test_region_edges();
        send_pixel_op(irf_pkg::OP_ROTATE, 0, 0, 64, 0, 3);
        send_pixel_op(irf_pkg::OP_READ, 0, 0);
        send_pixel_op(irf_pkg::OP_FLIP, 0, 0, 64, 64, 0, irf_pkg::FLIP_LR);
        send_pixel_op(irf_pkg::OP_FLIP, 0, 0, 64, 64, 0, irf_pkg::FLIP_UD);
        send_pixel_op(irf_pkg::OP_READ, 63, 0);
        send_pixel_op(irf_pkg::OP_ROTATE, 2, 3, 0, 5, 1);
        send_pixel_op(irf_pkg::OP_ROTATE, 63, 63, 1, 0, 2);
        send_pixel_op(irf_pkg::OP_ROTATE, 0, 0, 5, 127, 0);
        send_pixel_op(irf_pkg::OP_FLIP, 0, 0, 0, 7, 0, irf_pkg::FLIP_LR);
        send_pixel_op(irf_pkg::OP_FLIP, 0, 0, 7, 0, 0, irf_pkg::FLIP_UD);
        send_pixel_op(irf_pkg::OP_FLIP, 0, 60, 3, 3, 0, irf_pkg::FLIP_LR);
        send_pixel_op(irf_pkg::OP_FLIP, 61, 0, 3, 5, 0, irf_pkg::FLIP_UD);
        send_pixel_op(irf_pkg::OP_ROTATE, 60, 0, 8, 0, 1);
        send_pixel_op(irf_pkg::OP_FLIP, 1, 0, 64, 1, 0, irf_pkg::FLIP_UD);
        send_pixel_op(irf_pkg::OP_FLIP, 0, 1, 1, 64, 0, irf_pkg::FLIP_LR);
        send_pixel_op(irf_pkg::OP_ROTATE, 0, 127 & 63, 127, 0, 3);
    endtask

    // Random items, mostly in a small window so that reads find written pixels.
    task automatic test_random_ops(int idle_pct, int stall_pct);
        int kind, row, col, h, w, span;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            span = ($urandom_range(9) == 0) ? 63 : 15;
            row  = $urandom_range(span);
            col  = $urandom_range(span);
            if (kind < 30) begin
                send_pixel_op(irf_pkg::OP_WRITE, row, col, $urandom_range(127),
                              $urandom_range(127), $urandom_range(3),
                              1'($urandom_range(1)), 8'($urandom_range(255)));
            end else if (kind < 55) begin
                for (int k = 0; k < 40 && !written[row][col]; k++) begin
                    row = $urandom_range(15);
                    col = $urandom_range(15);
                end
                if (written[row][col])
                    send_pixel_op(irf_pkg::OP_READ, row, col, $urandom_range(127),
                                  $urandom_range(127), $urandom_range(3),
                                  1'($urandom_range(1)), 8'($urandom_range(255)));
                else
                    send_pixel_op(irf_pkg::OP_WRITE, row, col, 0, 0, 0, irf_pkg::FLIP_LR,
                                  8'($urandom_range(255)));
            end else begin
                case ($urandom_range(19))
                    0: begin h = $urandom_range(64); w = $urandom_range(64); end
                    1, 2: begin h = $urandom_range(64, 20); w = $urandom_range(64, 20); end
                    default: begin h = $urandom_range(9); w = $urandom_range(9); end
                endcase
                send_pixel_op((kind < 78) ? irf_pkg::OP_ROTATE : irf_pkg::OP_FLIP, row, col,
                              h, w, $urandom_range(3), 1'($urandom_range(1)),
                              8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_pixels();
        test_region_edges();
        test_random_ops(0, 0);
        test_random_ops(88, 0);
        test_random_ops(0, 88);
        test_random_ops(26, 26);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (n_errors == 0) begin
            $display("PASS image_region_rotate_flip");
        end else begin
            $display("FAIL image_region_rotate_flip");
        end
        $finish;
    end

endmodule
`default_nettype wire
